>>> hdl/keyword_number_identifier_lexer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyword/number/identifier lexer
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_NUMBER_IDENTIFIER_LEXER_UNIT_MACROS_SVH
`define KEYWORD_NUMBER_IDENTIFIER_LEXER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset
`define KNIL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define KNIL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/knil_pkg.sv
// ----------------------------------------------------------------------------
// knil_pkg
// Shared types, character constants and keyword tables for the lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package knil_pkg;

  localparam int POS_BITS_DEFAULT = 16;
  localparam int TOKEN_W          = 16;
  localparam int KW_COUNT         = 6;
  localparam int RQ_DEPTH         = 4;
  localparam int RQ_PTR_W         = $clog2(RQ_DEPTH);

  typedef enum logic [3:0] {
    TK_FUNCTION  = 4'd0,
    TK_LET       = 4'd1,
    TK_TYPE      = 4'd2,
    TK_RETURN    = 4'd3,
    TK_EQ        = 4'd4,
    TK_NUMBER    = 4'd5,
    TK_BOOL      = 4'd6,
    TK_IDENT     = 4'd7,
    TK_SEMICOLON = 4'd8,
    TK_COLON     = 4'd9,
    TK_END       = 4'd10,
    TK_UNKNOWN   = 4'd11
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_WORD   = 2'd2
  } run_mode_t;

  // Character codes
  localparam logic [7:0] CH_EQ         = 8'h3D;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;

  // Keyword spellings, left aligned, zero padded to eight bytes
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'("function"),
    {"let", 40'h0},
    {"type", 32'h0},
    {"return", 16'h0},
    {"true", 32'h0},
    {"false", 24'h0}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd8, 4'd3, 4'd4, 4'd6, 4'd4, 4'd5};
  localparam token_kind_t KW_TOKEN [KW_COUNT] = '{
    TK_FUNCTION, TK_LET, TK_TYPE, TK_RETURN, TK_BOOL, TK_BOOL
  };

  typedef struct packed {
    token_kind_t          kind;
    logic [TOKEN_W-1:0]   start;
    logic [TOKEN_W-1:0]   length;
    logic                 last;
  } result_t;

  // Up to two results from one item, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic dec_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

  // Byte i of keyword k
  function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
    logic [63:0] s;
    s = KW_TEXT[k] << {i, 3'b000};
    return s[63:56];
  endfunction

endpackage

`default_nettype wire

>>> hdl/keyword_number_identifier_lexer_unit.sv
// Path: a request is held in the input register, then its tokens are written to
// the result queue, from which the output port offers them one at a time.
// Throughput: one request per cycle while the result queue has room and each
// yields at most one token; the single-token output paces two-token requests.
// Reset: synchronous, clears the token state, position and the result queue.
// After the end token, further requests are taken and dropped until reset.
// ----------------------------------------------------------------------------
// keyword_number_identifier_lexer_unit
// Streaming tokenizer for numbers, identifiers, keywords and punctuation.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_number_identifier_lexer_unit import knil_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  logic               kind,
  input  logic [7:0]         ch,
  output logic               tok_valid,
  input  logic               tok_ready,
  output logic [3:0]         token_kind,
  output logic [TOKEN_W-1:0] token_start,
  output logic [TOKEN_W-1:0] token_length,
  output logic               last
);

  push_t   push;
  logic    room;
  result_t head;

  // Decode bytes into tokens
  knil_scan #(
    .POS_BITS (POS_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .kind      (kind),
    .ch        (ch),
    .room      (room),
    .push      (push)
  );

  // Queue tokens for the output port
  knil_rq u_rq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .head      (head)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign last         = head.last;

endmodule

`default_nettype wire

>>> hdl/knil_scan.sv
// ----------------------------------------------------------------------------
// knil_scan
// Input register, token state and combinational token decision logic.
// ----------------------------------------------------------------------------
`default_nettype none

module knil_scan import knil_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_ready,
  input  logic       kind,
  input  logic [7:0] ch,
  input  logic       room,
  output push_t      push
);

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  logic                stage_valid;
  logic                stage_kind;
  logic [7:0]          stage_ch;
  logic                advance;

  run_mode_t           run_mode, run_mode_next;
  logic [POS_BITS-1:0] run_start, run_start_next;
  logic [POS_BITS-1:0] run_length, run_length_next;
  logic [KW_COUNT-1:0] keyword_alive, keyword_alive_next;
  logic [POS_BITS-1:0] position, position_next;
  logic                finished, finished_next;

  logic                c_digit, c_letter, c_space;
  logic                flush_valid, fresh_valid;
  token_kind_t         word_kind, fresh_kind;
  result_t             flush_res, fresh_res;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [TOKEN_W-1:0] to_tok(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[TOKEN_W-1:0];
  endfunction

  assign advance   = stage_valid && room;
  assign src_ready = !stage_valid || room;

  // Hold one request until the result queue has room
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (src_valid && src_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      stage_kind <= kind;
      stage_ch   <= ch;
    end
  end

  // Token state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode      <= MODE_IDLE;
      run_start     <= '0;
      run_length    <= '0;
      keyword_alive <= '0;
      position      <= '0;
      finished      <= 1'b0;
    end else begin
      run_mode      <= run_mode_next;
      run_start     <= run_start_next;
      run_length    <= run_length_next;
      keyword_alive <= keyword_alive_next;
      position      <= position_next;
      finished      <= finished_next;
    end
  end

  assign c_digit  = dec_digit(stage_ch);
  assign c_letter = is_letter(stage_ch);
  assign c_space  = is_space(stage_ch);

  // Resolve a finished word against the keywords still alive
  always_comb begin
    word_kind = TK_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (keyword_alive[k] && run_length == POS_BITS'(KW_LEN[k])) begin
        word_kind = KW_TOKEN[k];
      end
    end
  end

  // Next state and emitted tokens
  always_comb begin
    run_mode_next      = run_mode;
    run_start_next     = run_start;
    run_length_next    = run_length;
    keyword_alive_next = keyword_alive;
    position_next      = position;
    finished_next      = finished;
    flush_valid        = 1'b0;
    fresh_valid        = 1'b0;
    fresh_kind         = TK_UNKNOWN;

    if (advance && !finished) begin
      if (stage_kind) begin
        // End of input: flush, then end token
        flush_valid        = (run_mode != MODE_IDLE);
        fresh_valid        = 1'b1;
        fresh_kind         = TK_END;
        run_mode_next      = MODE_IDLE;
        run_length_next    = '0;
        keyword_alive_next = '0;
        finished_next      = 1'b1;
      end else begin
        position_next = sat_inc(position);
        if (run_mode == MODE_NUMBER && c_digit) begin
          run_length_next = sat_inc(run_length);
        end else if (run_mode == MODE_WORD &&
                     (c_letter || c_digit || stage_ch == CH_UNDERSCORE)) begin
          for (int k = 0; k < KW_COUNT; k++) begin
            if (run_length >= POS_BITS'(KW_LEN[k]) ||
                kw_char(k, run_length[2:0]) != stage_ch) begin
              keyword_alive_next[k] = 1'b0;
            end
          end
          run_length_next = sat_inc(run_length);
        end else begin
          // Close any open run, then treat the byte as a fresh start
          flush_valid        = (run_mode != MODE_IDLE);
          run_mode_next      = MODE_IDLE;
          run_length_next    = '0;
          keyword_alive_next = '0;
          if (c_space) begin
            run_mode_next = MODE_IDLE;
          end else if (c_digit) begin
            run_mode_next   = MODE_NUMBER;
            run_start_next  = position;
            run_length_next = POS_BITS'(1);
          end else if (c_letter) begin
            run_mode_next   = MODE_WORD;
            run_start_next  = position;
            run_length_next = POS_BITS'(1);
            for (int k = 0; k < KW_COUNT; k++) begin
              keyword_alive_next[k] = (kw_char(k, 3'd0) == stage_ch);
            end
          end else begin
            fresh_valid = 1'b1;
            case (stage_ch)
              CH_EQ:    fresh_kind = TK_EQ;
              CH_SEMI:  fresh_kind = TK_SEMICOLON;
              CH_COLON: fresh_kind = TK_COLON;
              default:  fresh_kind = TK_UNKNOWN;
            endcase
          end
        end
      end
    end
  end

  // Build and order the results
  always_comb begin
    flush_res.kind   = (run_mode == MODE_WORD) ? word_kind : TK_NUMBER;
    flush_res.start  = to_tok(run_start);
    flush_res.length = to_tok(run_length);
    flush_res.last   = !fresh_valid;

    fresh_res.kind   = fresh_kind;
    fresh_res.start  = to_tok(position);
    fresh_res.length = stage_kind ? '0 : TOKEN_W'(1);
    fresh_res.last   = 1'b1;

    push.count  = {flush_valid && fresh_valid, flush_valid ^ fresh_valid};
    push.first  = flush_valid ? flush_res : fresh_res;
    push.second = fresh_res;
  end

endmodule

`default_nettype wire

>>> hdl/knil_rq.sv
// ----------------------------------------------------------------------------
// knil_rq
// Small result queue: takes up to two results a cycle when it has room, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module knil_rq import knil_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    tok_valid,
  input  logic    tok_ready,
  output result_t head
);

  localparam int CNT_W = RQ_PTR_W + 1;

  result_t             mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr, rd_ptr, wr_ptr_p1;
  logic [CNT_W-1:0]    count, count_next;
  logic                pop;

  assign pop        = tok_valid && tok_ready;
  assign tok_valid  = (count != '0);
  assign head       = mem[rd_ptr];
  assign wr_ptr_p1  = wr_ptr + 1'b1;
  // Room for two without looking at this cycle's pop
  assign room       = (count <= CNT_W'(RQ_DEPTH - 2));
  assign count_next = count + CNT_W'(push.count) - CNT_W'(pop);

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_p1] <= push.second;
    end
  end

endmodule

`default_nettype wire

>>> hdl/knil_chk.sv
// ----------------------------------------------------------------------------
// knil_chk
// Port-level checks on the lexer's token stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyword_number_identifier_lexer_unit_macros.svh"

module knil_chk import knil_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_ready,
  input  logic               tok_valid,
  input  logic               tok_ready,
  input  logic [3:0]         token_kind,
  input  logic [TOKEN_W-1:0] token_start,
  input  logic [TOKEN_W-1:0] token_length,
  input  logic               last
);

  logic                   tok_stall;
  logic                   end_shown;
  logic                   one_byte_shown;
  logic [2*TOKEN_W+4:0]   tok_word;

  // Gather the shown token and the conditions the checks key on
  assign tok_stall      = tok_valid && !tok_ready;
  assign end_shown      = tok_valid && token_kind == TK_END;
  assign one_byte_shown = tok_valid &&
                          (token_kind inside {TK_EQ, TK_SEMICOLON, TK_COLON, TK_UNKNOWN});
  assign tok_word       = {token_kind, token_start, token_length, last};

  // Reset empties the queue and opens the input
  `KNIL_ASSERT_ALWAYS(a_reset_clears, rst |=> !tok_valid && src_ready, "reset did not clear")

  // A stalled token holds
  `KNIL_ASSERT(a_tok_hold, tok_stall |=> tok_valid && $stable(tok_word), "stalled token changed")

  // End token is empty and closes its request
  `KNIL_ASSERT(a_end_shape, end_shown |-> token_length == '0 && last, "bad end token")

  // Nothing follows the end token
  `KNIL_ASSERT(a_end_final, end_shown && tok_ready |=> !tok_valid, "token after end")

  // Punctuation and unknown bytes are one byte long
  `KNIL_ASSERT(a_single_len, one_byte_shown |-> token_length == TOKEN_W'(1), "bad length")

endmodule

bind keyword_number_identifier_lexer_unit knil_chk u_chk (.*);

`default_nettype wire
